/* rtl/rsas_pkg.sv */
// ----------------------------------------------------------------------------
// rsas_pkg
// Shared types and constants for the rotated sorted array search core.
// ----------------------------------------------------------------------------
package rsas_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = $clog2(DEPTH);   // element address width
    localparam int CW    = AW + 1;          // element count width
    localparam int BW    = AW + 2;          // signed search bound width
    localparam int POS_W = 10;              // result position field width

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_CLEAR  = 2'd2
    } t_func;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_out_word;

endpackage

/* rtl/rotated_sorted_array_search_core.sv */
// ----------------------------------------------------------------------------
// rotated_sorted_array_search_core
// Element store with pivot tracking and two-range binary search.
// ----------------------------------------------------------------------------
// Append and clear words are taken while idle and give no result. A search word
// gives one result word. Each probe of the element memory presents the address
// (S_RANGE), then compares the registered read data (S_CMP). A search passes
// through acceptance, its probes, a step to move to the second range, a step
// when nothing matches and a step to load the result register. Over a full
// store of 1024 elements the two ranges together need at most 20 probes. The
// result step waits while the previous result word is still stalled.
// Input is stalled while a search runs. Elements beyond capacity are dropped.
module rotated_sorted_array_search_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rsas_pkg::t_in_word   i_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rsas_pkg::t_out_word  o_word
);
    import rsas_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RANGE,
        S_CMP,
        S_FIN
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_pivot, n_pivot;
    logic               r_seen, n_seen;
    logic signed [31:0] r_last, n_last;
    logic signed [31:0] r_target, n_target;
    logic signed [BW-1:0] r_lo, n_lo;
    logic signed [BW-1:0] r_hi, n_hi;
    logic [AW-1:0]      r_mid, n_mid;
    logic               r_phase2, n_phase2;
    t_out_word          r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    logic               wr_en;
    logic signed [31:0] r_rd_data;
    logic signed [BW-1:0] sum;
    logic signed [BW-1:0] mid_ext;
    logic signed [BW-1:0] last_idx;

    logic signed [31:0] mem [DEPTH];

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    assign sum      = r_lo + r_hi;
    assign mid_ext  = $signed({2'b00, r_mid});
    assign last_idx = $signed({1'b0, r_count}) - BW'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pivot     = r_pivot;
        n_seen      = r_seen;
        n_last      = r_last;
        n_target    = r_target;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_phase2    = r_phase2;
        n_res       = r_res;
        n_out_valid = r_out_valid & i_stall;
        n_out       = r_out;
        wr_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_word.func)
                        FUNC_APPEND: begin
                            if (r_count < CW'(DEPTH)) begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                                n_last  = i_word.value;
                                // only the first strict decrease marks the pivot
                                if (r_count != '0 && !r_seen && r_last > i_word.value) begin
                                    n_pivot = AW'(r_count - CW'(1));
                                    n_seen  = 1'b1;
                                end
                            end
                        end
                        FUNC_CLEAR: begin
                            n_count = '0;
                            n_pivot = '0;
                            n_seen  = 1'b0;
                        end
                        FUNC_SEARCH: begin
                            n_target = i_word.value;
                            n_lo     = '0;
                            if (r_seen) begin
                                n_hi     = $signed({2'b00, r_pivot});
                                n_phase2 = 1'b0;
                            end else begin
                                n_hi     = last_idx;
                                n_phase2 = 1'b1;
                            end
                            n_state = S_RANGE;
                        end
                        default: ;
                    endcase
                end
            end
            S_RANGE: begin
                if (r_lo <= r_hi) begin
                    // bounds are non-negative here, so floor midpoint is a shift
                    n_mid   = sum[AW:1];
                    n_state = S_CMP;
                end else if (!r_phase2) begin
                    n_lo     = $signed({2'b00, r_pivot}) + BW'(1);
                    n_hi     = last_idx;
                    n_phase2 = 1'b1;
                end else begin
                    n_res.found    = 1'b0;
                    n_res.position = '0;
                    n_state        = S_FIN;
                end
            end
            S_CMP: begin
                if (r_rd_data == r_target) begin
                    n_res.found    = 1'b1;
                    n_res.position = POS_W'(r_mid);
                    n_state        = S_FIN;
                end else begin
                    if (r_rd_data > r_target) begin
                        n_hi = mid_ext - BW'(1);
                    end else begin
                        n_lo = mid_ext + BW'(1);
                    end
                    n_state = S_RANGE;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pivot     <= '0;
            r_seen      <= 1'b0;
            r_phase2    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pivot     <= n_pivot;
            r_seen      <= n_seen;
            r_phase2    <= n_phase2;
            r_out_valid <= n_out_valid;
        end
        r_last   <= n_last;
        r_target <= n_target;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    // element memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= i_word.value;
        end
        r_rd_data <= mem[n_mid];
    end

endmodule

/* tb/tb_rotated_sorted_array_search_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotated_sorted_array_search_core
// Drives append, search and clear words into the search core, keeps its own
// copy of the element array and pivot, and checks every result word against
// the search it predicts. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_rotated_sorted_array_search_core;
    import rsas_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int IDLE_PCT = 23;

    typedef struct {
        logic [1:0]         func;
        logic signed [31:0] value;
        bit                 typed;
        t_out_word          result;
    } t_step;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_word  = '0;
    logic      o_valid;
    logic      i_stall = 1'b1;
    t_out_word o_word;

    rotated_sorted_array_search_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_word (i_word),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_word (o_word)
    );

    // mirror of the block state
    logic signed [31:0] elems [DEPTH];
    int                 elem_count = 0;
    int                 pivot_at   = 0;
    bit                 pivot_seen = 1'b0;

    t_out_word expected_hits[$];
    int        errors = 0;
    int        accepted_items = 0;
    bit        no_idle = 1'b0;
    t_step     directed[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_500_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int probe_range(int lo, int hi, logic signed [31:0] target);
        int mid;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (mid < 0 || mid >= elem_count) return -1;
            if (elems[mid] == target) return mid;
            if (elems[mid] > target) hi = mid - 1;
            else lo = mid + 1;
        end
        return -1;
    endfunction

    // update the mirror with one accepted word, queue the result of a search
    function automatic void track_word(t_in_word w, bit typed, t_out_word typed_res);
        int        hit;
        t_out_word res;
        case (w.func)
            FUNC_APPEND: begin
                if (elem_count < DEPTH) begin
                    if (elem_count > 0 && !pivot_seen && elems[elem_count-1] > w.value) begin
                        pivot_at   = elem_count - 1;
                        pivot_seen = 1'b1;
                    end
                    elems[elem_count] = w.value;
                    elem_count++;
                end
            end
            FUNC_CLEAR: begin
                elem_count = 0;
                pivot_at   = 0;
                pivot_seen = 1'b0;
            end
            FUNC_SEARCH: begin
                if (!pivot_seen) begin
                    hit = probe_range(0, elem_count - 1, w.value);
                end else begin
                    hit = probe_range(0, pivot_at, w.value);
                    if (hit < 0) hit = probe_range(pivot_at + 1, elem_count - 1, w.value);
                end
                res.found    = (hit >= 0);
                res.position = (hit >= 0) ? hit[POS_W-1:0] : '0;
                expected_hits = {expected_hits, (typed ? typed_res : res)};
            end
            default: ;
        endcase
    endfunction

    // called right after a falling edge, returns right after a falling edge
    task automatic send_word(t_in_word w, bit typed, t_out_word typed_res);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_stall);
        track_word(w, typed, typed_res);
        if (w.func != FUNC_UNUSED) accepted_items++;
        @(negedge i_clk);
    endtask

    task automatic send(logic [1:0] func, int value);
        t_in_word w;
        w.func  = func;
        w.value = value;
        send_word(w, 1'b0, '0);
    endtask

    function automatic t_step step(logic [1:0] func, int value, bit typed = 1'b0,
                                   bit found = 1'b0, int pos = 0);
        t_step s;
        s.func            = func;
        s.value           = value;
        s.typed           = typed;
        s.result.found    = found;
        s.result.position = pos[POS_W-1:0];
        return s;
    endfunction

    function automatic void add_row(t_step s);
        directed = {directed, s};
    endfunction

    function automatic int rand_value(bit narrow);
        return narrow ? int'($urandom_range(16)) - 8 : int'($urandom);
    endfunction

    function automatic int pick_target(int vals[$], bit narrow);
        int t;
        if (vals.size() > 0 && $urandom_range(9) < 7) begin
            t = vals[$urandom_range(vals.size() - 1)];
            if ($urandom_range(4) == 0) t = $urandom_range(1) ? t + 1 : t - 1;
            return t;
        end
        return rand_value(narrow);
    endfunction

    // clear, then a rotated ascending run, then searches
    task automatic rotated_run(int n, bit narrow, int nsearch);
        int vals[$];
        int k;
        send(FUNC_CLEAR, $urandom);
        for (int i = 0; i < n; i++) vals = {vals, rand_value(narrow)};
        vals.sort();
        k = (n > 0) ? $urandom_range(n - 1) : 0;
        for (int i = 0; i < n; i++) send(FUNC_APPEND, vals[(i + k) % n]);
        // appends past capacity must be dropped
        if (n >= DEPTH) repeat (6) send(FUNC_APPEND, rand_value(narrow));
        for (int j = 0; j < nsearch; j++) send(FUNC_SEARCH, pick_target(vals, narrow));
    endtask

    task automatic random_sequence();
        int  kind;
        bit  narrow;
        int  f;
        kind   = $urandom_range(99);
        narrow = $urandom_range(1);
        if (kind < 75) begin
            rotated_run(($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(24),
                        narrow, $urandom_range(3, 8));
        end else begin
            // unsorted appends, stray clears, unused codes
            repeat ($urandom_range(4, 16)) begin
                f = $urandom_range(99);
                if (f < 55) send(FUNC_APPEND, rand_value(narrow));
                else if (f < 85) send(FUNC_SEARCH, rand_value(narrow));
                else if (f < 93) send(FUNC_CLEAR, rand_value(narrow));
                else send(FUNC_UNUSED, rand_value(narrow));
            end
        end
    endtask

    // result side
    always @(negedge i_clk) begin
        i_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_hits.size() == 0) begin
                $error("unexpected result word: found %0d position %0d",
                       o_word.found, o_word.position);
                errors++;
            end else begin
                want = expected_hits.pop_front();
                if (o_word.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_word.found);
                    errors++;
                end
                if (o_word.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_word.position);
                    errors++;
                end
            end
        end
    end

    initial begin
        int seq;
        int timeout_cycles;

        // empty store, unused code, extremes
        add_row(step(FUNC_SEARCH, 5, 1, 0, 0));
        add_row(step(FUNC_UNUSED, 32'h7fff_ffff));
        add_row(step(FUNC_SEARCH, 7, 1, 0, 0));
        add_row(step(FUNC_APPEND, 32'h8000_0000));
        add_row(step(FUNC_APPEND, 32'h7fff_ffff));
        add_row(step(FUNC_SEARCH, 32'h8000_0000, 1, 1, 0));
        add_row(step(FUNC_SEARCH, 32'h7fff_ffff, 1, 1, 1));
        add_row(step(FUNC_SEARCH, 0, 1, 0, 0));
        add_row(step(FUNC_CLEAR, -1));
        add_row(step(FUNC_SEARCH, 32'h8000_0000, 1, 0, 0));
        // rotated run with the pivot after the third element
        add_row(step(FUNC_APPEND, 10));
        add_row(step(FUNC_APPEND, 20));
        add_row(step(FUNC_APPEND, 30));
        add_row(step(FUNC_APPEND, -5));
        add_row(step(FUNC_APPEND, 0));
        add_row(step(FUNC_SEARCH, 30));
        add_row(step(FUNC_SEARCH, -5));
        add_row(step(FUNC_SEARCH, 0));
        add_row(step(FUNC_SEARCH, 15));
        // duplicates: only a strict drop marks the pivot
        add_row(step(FUNC_CLEAR, 0));
        add_row(step(FUNC_APPEND, 5));
        add_row(step(FUNC_APPEND, 5));
        add_row(step(FUNC_APPEND, 3));
        add_row(step(FUNC_APPEND, 3));
        add_row(step(FUNC_SEARCH, 3));
        add_row(step(FUNC_SEARCH, 5));
        add_row(step(FUNC_UNUSED, -1));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) begin
            t_in_word w;
            w.func  = directed[i].func;
            w.value = directed[i].value;
            send_word(w, directed[i].typed, directed[i].result);
        end

        accepted_items = 0;
        seq = 0;
        while (accepted_items < RANDOM_ITEMS) begin
            no_idle = (seq >= 10 && seq < 18);
            random_sequence();
            seq++;
        end
        no_idle = 1'b0;

        i_valid <= 1'b0;
        wait (expected_hits.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
